FILE: hdl/archive_path_sanitizer_core_macros.svh
// Assertion macros shared by the archive path sanitizer RTL.
// Included by the top level; depends on nothing else.
`ifndef ARCHIVE_PATH_SANITIZER_CORE_MACROS_SVH
`define ARCHIVE_PATH_SANITIZER_CORE_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define APSAN_ASSERT_IMPLIES(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled during reset.
`define APSAN_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

FILE: hdl/apsan_pkg.sv
// Shared types and constants for the archive path sanitizer.
// Used by the front, queue, back and top-level modules; depends on nothing.
package apsan_pkg;

   localparam int PATH_BUFFER_BYTES_DEFAULT = 512;
   localparam int QUEUE_DEPTH = 4;
   localparam logic [8:0] LENGTH_MAX = 9'd511;
   localparam logic [8:0] MAX_LENGTH_RESET = 9'd511;

   localparam logic [7:0] CH_DOT = 8'h2E;
   localparam logic [7:0] CH_SLASH = 8'h2F;

   localparam logic [0:0] CSR_STRIP_DEPTH = 1'd0;
   localparam logic [0:0] CSR_MAX_LENGTH = 1'd1;

   localparam logic [1:0] DS_IN_NAME = 2'd0;
   localparam logic [1:0] DS_AFTER_SEP = 2'd1;
   localparam logic [1:0] DS_ONE_DOT = 2'd2;
   localparam logic [1:0] DS_TWO_DOTS = 2'd3;

   localparam logic [2:0] VERDICT_OK = 3'd0;
   localparam logic [2:0] VERDICT_ABSOLUTE = 3'd1;
   localparam logic [2:0] VERDICT_BACKTRAVERSAL = 3'd2;
   localparam logic [2:0] VERDICT_DOT_ENDING = 3'd3;
   localparam logic [2:0] VERDICT_TOO_SHALLOW = 3'd4;
   localparam logic [2:0] VERDICT_TOO_LONG = 3'd5;

   // Everything one input item produces: up to three path bytes and a verdict.
   typedef struct packed {
      logic [1:0]      byte_count;
      logic [2:0][7:0] out_bytes;
      logic            has_verdict;
      logic [2:0]      verdict;
      logic [8:0]      length;
   } bundle_type;

   typedef struct packed {
      logic full;
      logic empty;
   } queue_status_type;

endpackage

FILE: hdl/apsan_queue.sv
// Short queue of result bundles between the front and the back.
// Depends on apsan_pkg.
module apsan_queue (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       push,
   input  apsan_pkg::bundle_type      push_data,
   input  logic                       pop,
   output apsan_pkg::bundle_type      head,
   output apsan_pkg::queue_status_type status
);

   localparam int Depth = apsan_pkg::QUEUE_DEPTH;
   localparam int PtrWidth = $clog2(Depth);
   localparam int CountWidth = $clog2(Depth + 1);

   apsan_pkg::bundle_type entry_ff [Depth];
   logic [PtrWidth-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PtrWidth-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CountWidth-1:0] count_ff, count_in;

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

   assign head = entry_ff[rd_ptr_ff];
   assign status.full = (count_ff == CountWidth'(Depth));
   assign status.empty = (count_ff == '0);

endmodule

FILE: hdl/apsan_front.sv
// Front end: configuration registers, per-path state and classification of
// each path byte into a bundle of results. Depends on apsan_pkg.
module apsan_front #(
   parameter int PATH_BUFFER_BYTES = apsan_pkg::PATH_BUFFER_BYTES_DEFAULT
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_write_enable,
   input  logic [0:0]            csr_index,
   input  logic [8:0]            csr_write_data,
   input  logic                  accept,
   input  logic [7:0]            path_byte,
   input  logic                  first_byte,
   input  logic                  last_byte,
   output logic                  push,
   output apsan_pkg::bundle_type bundle
);

   localparam int CapInt = PATH_BUFFER_BYTES - 1;
   localparam logic CapApplies = (CapInt < int'(apsan_pkg::LENGTH_MAX));
   localparam logic [8:0] Cap = 9'(CapInt);

   logic [7:0] strip_depth_ff;
   logic [8:0] max_length_ff;

   logic [1:0] dot_state_ff, dot_state_in;
   logic [7:0] depth_left_ff, depth_left_in;
   logic [8:0] emitted_count_ff, emitted_count_in;
   logic [2:0] reject_code_ff, reject_code_in;

   logic [8:0]      limit;
   logic [1:0]      want_count;
   logic [2:0][7:0] want_bytes;
   logic [1:0]      put_count;

   always_comb begin
      limit = (CapApplies && (max_length_ff > Cap)) ? Cap : max_length_ff;
   end

   always_comb begin
      dot_state_in = dot_state_ff;
      depth_left_in = depth_left_ff;
      emitted_count_in = emitted_count_ff;
      reject_code_in = reject_code_ff;
      want_count = 2'd0;
      want_bytes = '0;
      put_count = 2'd0;
      bundle = '0;

      if (first_byte) begin
         dot_state_in = apsan_pkg::DS_AFTER_SEP;
         depth_left_in = strip_depth_ff;
         emitted_count_in = '0;
         reject_code_in = apsan_pkg::VERDICT_OK;
         if (path_byte == apsan_pkg::CH_SLASH) begin
            reject_code_in = apsan_pkg::VERDICT_ABSOLUTE;
         end
      end

      if (reject_code_in == apsan_pkg::VERDICT_OK) begin
         if (path_byte == apsan_pkg::CH_DOT) begin
            case (dot_state_in)
               apsan_pkg::DS_IN_NAME: begin
                  want_count = 2'd1;
                  want_bytes[0] = apsan_pkg::CH_DOT;
               end
               apsan_pkg::DS_AFTER_SEP: dot_state_in = apsan_pkg::DS_ONE_DOT;
               apsan_pkg::DS_ONE_DOT: dot_state_in = apsan_pkg::DS_TWO_DOTS;
               default: begin
                  dot_state_in = apsan_pkg::DS_IN_NAME;
                  want_count = 2'd3;
                  want_bytes = {3{apsan_pkg::CH_DOT}};
               end
            endcase
         end else if (path_byte == apsan_pkg::CH_SLASH) begin
            case (dot_state_in)
               apsan_pkg::DS_IN_NAME: begin
                  if (depth_left_in == '0) begin
                     want_count = 2'd1;
                     want_bytes[0] = apsan_pkg::CH_SLASH;
                  end else begin
                     depth_left_in = depth_left_in - 8'd1;
                  end
                  dot_state_in = apsan_pkg::DS_AFTER_SEP;
               end
               apsan_pkg::DS_ONE_DOT: dot_state_in = apsan_pkg::DS_AFTER_SEP;
               apsan_pkg::DS_TWO_DOTS: reject_code_in = apsan_pkg::VERDICT_BACKTRAVERSAL;
               default: dot_state_in = dot_state_in;
            endcase
         end else begin
            case (dot_state_in)
               apsan_pkg::DS_ONE_DOT: begin
                  want_count = 2'd2;
                  want_bytes[0] = apsan_pkg::CH_DOT;
                  want_bytes[1] = path_byte;
               end
               apsan_pkg::DS_TWO_DOTS: begin
                  want_count = 2'd3;
                  want_bytes[0] = apsan_pkg::CH_DOT;
                  want_bytes[1] = apsan_pkg::CH_DOT;
                  want_bytes[2] = path_byte;
               end
               default: begin
                  want_count = 2'd1;
                  want_bytes[0] = path_byte;
               end
            endcase
            dot_state_in = apsan_pkg::DS_IN_NAME;
         end
      end

      // Each wanted byte is checked against stripping, rejection and the limit in order.
      for (int i = 0; i < 3; i++) begin
         if ((2'(i) < want_count) && (reject_code_in == apsan_pkg::VERDICT_OK)
               && (depth_left_in == '0)) begin
            if (emitted_count_in >= limit) begin
               reject_code_in = apsan_pkg::VERDICT_TOO_LONG;
            end else begin
               bundle.out_bytes[put_count] = want_bytes[i];
               put_count = put_count + 2'd1;
               emitted_count_in = emitted_count_in + 9'd1;
            end
         end
      end

      if (last_byte && (reject_code_in == apsan_pkg::VERDICT_OK)) begin
         if ((dot_state_in == apsan_pkg::DS_ONE_DOT)
               || (dot_state_in == apsan_pkg::DS_TWO_DOTS)) begin
            reject_code_in = apsan_pkg::VERDICT_DOT_ENDING;
         end else if (depth_left_in != '0) begin
            reject_code_in = apsan_pkg::VERDICT_TOO_SHALLOW;
         end
      end

      bundle.byte_count = put_count;
      bundle.has_verdict = last_byte;
      bundle.verdict = reject_code_in;
      bundle.length = emitted_count_in;
   end

   assign push = accept && ((put_count != 2'd0) || last_byte);

   always_ff @(posedge clock) begin
      if (reset) begin
         strip_depth_ff <= '0;
         max_length_ff <= apsan_pkg::MAX_LENGTH_RESET;
      end else if (csr_write_enable) begin
         unique case (csr_index)
            apsan_pkg::CSR_STRIP_DEPTH: strip_depth_ff <= csr_write_data[7:0];
            apsan_pkg::CSR_MAX_LENGTH: max_length_ff <= csr_write_data;
            default: strip_depth_ff <= strip_depth_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         dot_state_ff <= apsan_pkg::DS_AFTER_SEP;
         depth_left_ff <= '0;
         emitted_count_ff <= '0;
         reject_code_ff <= apsan_pkg::VERDICT_OK;
      end else if (accept) begin
         dot_state_ff <= dot_state_in;
         depth_left_ff <= depth_left_in;
         emitted_count_ff <= emitted_count_in;
         reject_code_ff <= reject_code_in;
      end
   end

endmodule

FILE: hdl/apsan_back.sv
// Back end: walks the bundle at the head of the queue and sends its results
// one per cycle while rsp_stall is low through the output register. Depends on apsan_pkg.
module apsan_back (
   input  logic                       clock,
   input  logic                       reset,
   input  apsan_pkg::bundle_type      head,
   input  apsan_pkg::queue_status_type status,
   output logic                       pop,
   output logic                       rsp_valid,
   input  logic                       rsp_stall,
   output logic [7:0]                 rsp_out_byte,
   output logic                       rsp_is_verdict,
   output logic [2:0]                 rsp_verdict,
   output logic [8:0]                 rsp_out_length,
   output logic                       rsp_end_of_run
);

   logic [1:0] index_ff, index_in;
   logic       valid_ff, valid_in;
   logic [7:0] out_byte_ff, out_byte_in;
   logic       is_verdict_ff, is_verdict_in;
   logic [2:0] verdict_ff, verdict_in;
   logic [8:0] out_length_ff, out_length_in;
   logic       end_of_run_ff, end_of_run_in;

   logic       load;
   logic       at_verdict;
   logic [2:0] total;
   logic       last_of_bundle;

   always_comb begin
      load = !status.empty && (!valid_ff || !rsp_stall);
      at_verdict = (index_ff == head.byte_count);
      total = {1'b0, head.byte_count} + {2'b0, head.has_verdict};
      last_of_bundle = (({1'b0, index_ff} + 3'd1) == total);
      pop = load && last_of_bundle;

      index_in = index_ff;
      if (load) begin
         index_in = last_of_bundle ? 2'd0 : index_ff + 2'd1;
      end

      valid_in = valid_ff;
      if (load) begin
         valid_in = 1'b1;
      end else if (!rsp_stall) begin
         valid_in = 1'b0;
      end

      out_byte_in = out_byte_ff;
      is_verdict_in = is_verdict_ff;
      verdict_in = verdict_ff;
      out_length_in = out_length_ff;
      end_of_run_in = end_of_run_ff;
      if (load) begin
         if (at_verdict) begin
            out_byte_in = 8'd0;
            is_verdict_in = 1'b1;
            verdict_in = head.verdict;
            out_length_in = head.length;
            end_of_run_in = 1'b1;
         end else begin
            out_byte_in = head.out_bytes[index_ff];
            is_verdict_in = 1'b0;
            verdict_in = apsan_pkg::VERDICT_OK;
            out_length_in = '0;
            end_of_run_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         index_ff <= '0;
         valid_ff <= 1'b0;
      end else begin
         index_ff <= index_in;
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      out_byte_ff <= out_byte_in;
      is_verdict_ff <= is_verdict_in;
      verdict_ff <= verdict_in;
      out_length_ff <= out_length_in;
      end_of_run_ff <= end_of_run_in;
   end

   assign rsp_valid = valid_ff;
   assign rsp_out_byte = out_byte_ff;
   assign rsp_is_verdict = is_verdict_ff;
   assign rsp_verdict = verdict_ff;
   assign rsp_out_length = out_length_ff;
   assign rsp_end_of_run = end_of_run_ff;

endmodule

FILE: hdl/archive_path_sanitizer_core.sv
// Top level of the archive path sanitizer: front end, bundle queue and back end.
// Depends on apsan_pkg, apsan_front, apsan_queue, apsan_back and the macro header.
//
// The block takes one path byte per cycle while req_stall is low and returns the
// cleaned path bytes followed by one verdict item on the path's last byte. A
// byte can produce up to three path bytes plus the verdict; the front end
// classifies each byte in the cycle it is accepted and writes its results, if
// any, as one bundle into a four-entry queue, and the back end sends one result
// per cycle through the output register while rsp_stall is low. Input is taken
// every cycle while the queue has room, so a stream of bytes that each yield at
// most one result runs at one item per cycle while rsp_stall stays low; the
// output side sets the sustained rate when bytes yield more. The first result of
// an item passes through a queue entry and then the output register to rsp_valid.
// Configuration takes effect on the next path byte; strip_depth is sampled at
// the first byte of a path.
`include "archive_path_sanitizer_core_macros.svh"

module archive_path_sanitizer_core #(
   parameter int PATH_BUFFER_BYTES = apsan_pkg::PATH_BUFFER_BYTES_DEFAULT
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       csr_write_enable,
   input  logic [0:0] csr_index,
   input  logic [8:0] csr_write_data,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [7:0] req_path_byte,
   input  logic       req_first_byte,
   input  logic       req_last_byte,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic [7:0] rsp_out_byte,
   output logic       rsp_is_verdict,
   output logic [2:0] rsp_verdict,
   output logic [8:0] rsp_out_length,
   output logic       rsp_end_of_run
);

   apsan_pkg::bundle_type       front_bundle;
   apsan_pkg::bundle_type       q_head;
   apsan_pkg::queue_status_type q_status;
   logic                        q_push;
   logic                        q_pop;
   logic                        req_accept;
   logic                        verdict_seen;
   logic                        byte_seen;
   logic                        verdict_ok;
   logic                        byte_ok;
   logic                        refill_due;

   assign req_stall = q_status.full;
   assign req_accept = req_valid && !req_stall;

   apsan_front #(
      .PATH_BUFFER_BYTES(PATH_BUFFER_BYTES)
   ) u_front (
      .clock(clock),
      .reset(reset),
      .csr_write_enable(csr_write_enable),
      .csr_index(csr_index),
      .csr_write_data(csr_write_data),
      .accept(req_accept),
      .path_byte(req_path_byte),
      .first_byte(req_first_byte),
      .last_byte(req_last_byte),
      .push(q_push),
      .bundle(front_bundle)
   );

   apsan_queue u_queue (
      .clock(clock),
      .reset(reset),
      .push(q_push),
      .push_data(front_bundle),
      .pop(q_pop),
      .head(q_head),
      .status(q_status)
   );

   apsan_back u_back (
      .clock(clock),
      .reset(reset),
      .head(q_head),
      .status(q_status),
      .pop(q_pop),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_out_byte(rsp_out_byte),
      .rsp_is_verdict(rsp_is_verdict),
      .rsp_verdict(rsp_verdict),
      .rsp_out_length(rsp_out_length),
      .rsp_end_of_run(rsp_end_of_run)
   );

   assign verdict_seen = rsp_valid && rsp_is_verdict;
   assign byte_seen = rsp_valid && !rsp_is_verdict;
   assign verdict_ok = rsp_end_of_run && (rsp_out_byte == 8'd0)
      && (rsp_verdict <= apsan_pkg::VERDICT_TOO_LONG);
   assign byte_ok = !rsp_end_of_run && (rsp_out_length == 9'd0);
   assign refill_due = rsp_valid && !rsp_stall && !q_status.empty;

   `APSAN_ASSERT_IMPLIES(a_push_not_full, clock, reset, q_push, !q_status.full, "queue overflow")
   `APSAN_ASSERT_IMPLIES(a_verdict_shape, clock, reset, verdict_seen, verdict_ok, "bad verdict")
   `APSAN_ASSERT_IMPLIES(a_byte_shape, clock, reset, byte_seen, byte_ok, "bad byte item")
   `APSAN_ASSERT_NEXT(a_back_refills, clock, reset, refill_due, rsp_valid, "output not refilled")

endmodule

FILE: bench/testbench.sv
`timescale 1ns / 100ps
// Self-checking testbench for archive_path_sanitizer_core: random and directed paths
// are checked byte by byte against a behavioral predictor. Depends on apsan_pkg and archive_path_sanitizer_core.
module testbench;

   localparam int CLOCK_PERIOD = 20;
   localparam int RESET_CYCLES = 11;
   localparam int SETTLE_CYCLES = 12;
   localparam int CYCLE_LIMIT = 600000;
   localparam int REPORT_LIMIT = 10;
   localparam int PHASE_ITEMS = 52;

   typedef struct packed {
      logic [7:0] path_byte;
      logic       first_flag;
      logic       last_flag;
   } path_item_type;

   typedef struct packed {
      logic [7:0] out_byte;
      logic       is_verdict;
      logic [2:0] verdict;
      logic [8:0] out_length;
      logic       end_of_run;
   } clean_out_type;

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       csr_write_enable = 1'b0;
   logic [0:0] csr_index = apsan_pkg::CSR_STRIP_DEPTH;
   logic [8:0] csr_write_data = '0;
   logic       req_valid = 1'b0;
   logic       req_stall;
   logic [7:0] req_path_byte = '0;
   logic       req_first_byte = 1'b0;
   logic       req_last_byte = 1'b0;
   logic       rsp_valid;
   logic       rsp_stall = 1'b0;
   logic [7:0] rsp_out_byte;
   logic       rsp_is_verdict;
   logic [2:0] rsp_verdict;
   logic [8:0] rsp_out_length;
   logic       rsp_end_of_run;

   path_item_type paths_to_send[$];
   clean_out_type clean_out_due[$];
   int         queued_count = 0;
   int         fail_count = 0;
   int         cycle_count = 0;
   int         send_gap = 0;
   int         stall_left = 0;
   bit         sender_idles = 1'b1;
   bit         receiver_stalls = 1'b1;

   logic [7:0] strip_setting = 8'd0;
   logic [8:0] length_setting = apsan_pkg::MAX_LENGTH_RESET;
   logic [1:0] dot_phase = apsan_pkg::DS_AFTER_SEP;
   logic [7:0] strip_left = 8'd0;
   logic [8:0] emitted_total = 9'd0;
   logic [2:0] reject_verdict = apsan_pkg::VERDICT_OK;

   archive_path_sanitizer_core DUT (
      .clock(clock),
      .reset(reset),
      .csr_write_enable(csr_write_enable),
      .csr_index(csr_index),
      .csr_write_data(csr_write_data),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_path_byte(req_path_byte),
      .req_first_byte(req_first_byte),
      .req_last_byte(req_last_byte),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_out_byte(rsp_out_byte),
      .rsp_is_verdict(rsp_is_verdict),
      .rsp_verdict(rsp_verdict),
      .rsp_out_length(rsp_out_length),
      .rsp_end_of_run(rsp_end_of_run)
   );

   always #(CLOCK_PERIOD / 2) clock = ~clock;

   function automatic int pick_gap(input bit enabled);
      int roll;
      roll = $urandom_range(0, 99);
      if (!enabled || roll < 65) return 0;
      if (roll < 95) return $urandom_range(1, 3);
      return $urandom_range(8, 25);
   endfunction

   function automatic void emit_clean_byte(input logic [7:0] value);
      clean_out_type item;
      int            cap;
      cap = (length_setting < apsan_pkg::PATH_BUFFER_BYTES_DEFAULT - 1) ?
            int'(length_setting) : apsan_pkg::PATH_BUFFER_BYTES_DEFAULT - 1;
      if (reject_verdict != apsan_pkg::VERDICT_OK || strip_left != 0) return;
      if (int'(emitted_total) >= cap) begin
         reject_verdict = apsan_pkg::VERDICT_TOO_LONG;
         return;
      end
      item = '0;
      item.out_byte = value;
      clean_out_due.push_back(item);
      emitted_total = emitted_total + 9'd1;
   endfunction

   function automatic void sanitize_path_byte(input logic [7:0] value,
                                              input logic first_flag,
                                              input logic last_flag);
      clean_out_type item;
      if (first_flag) begin
         dot_phase = apsan_pkg::DS_AFTER_SEP;
         strip_left = strip_setting;
         emitted_total = 9'd0;
         reject_verdict = (value == apsan_pkg::CH_SLASH) ? apsan_pkg::VERDICT_ABSOLUTE
                                                          : apsan_pkg::VERDICT_OK;
      end
      if (reject_verdict == apsan_pkg::VERDICT_OK) begin
         if (value == apsan_pkg::CH_DOT) begin
            case (dot_phase)
               apsan_pkg::DS_IN_NAME: emit_clean_byte(apsan_pkg::CH_DOT);
               apsan_pkg::DS_AFTER_SEP: dot_phase = apsan_pkg::DS_ONE_DOT;
               apsan_pkg::DS_ONE_DOT: dot_phase = apsan_pkg::DS_TWO_DOTS;
               default: begin
                  dot_phase = apsan_pkg::DS_IN_NAME;
                  emit_clean_byte(apsan_pkg::CH_DOT);
                  emit_clean_byte(apsan_pkg::CH_DOT);
                  emit_clean_byte(apsan_pkg::CH_DOT);
               end
            endcase
         end else if (value == apsan_pkg::CH_SLASH) begin
            if (dot_phase == apsan_pkg::DS_IN_NAME) begin
               if (strip_left == 0) emit_clean_byte(apsan_pkg::CH_SLASH);
               else strip_left = strip_left - 8'd1;
               dot_phase = apsan_pkg::DS_AFTER_SEP;
            end else if (dot_phase == apsan_pkg::DS_ONE_DOT) begin
               dot_phase = apsan_pkg::DS_AFTER_SEP;
            end else if (dot_phase == apsan_pkg::DS_TWO_DOTS) begin
               reject_verdict = apsan_pkg::VERDICT_BACKTRAVERSAL;
            end
         end else begin
            if (dot_phase == apsan_pkg::DS_ONE_DOT || dot_phase == apsan_pkg::DS_TWO_DOTS)
               emit_clean_byte(apsan_pkg::CH_DOT);
            if (dot_phase == apsan_pkg::DS_TWO_DOTS) emit_clean_byte(apsan_pkg::CH_DOT);
            emit_clean_byte(value);
            dot_phase = apsan_pkg::DS_IN_NAME;
         end
      end
      if (last_flag) begin
         if (reject_verdict == apsan_pkg::VERDICT_OK) begin
            if (dot_phase == apsan_pkg::DS_ONE_DOT || dot_phase == apsan_pkg::DS_TWO_DOTS)
               reject_verdict = apsan_pkg::VERDICT_DOT_ENDING;
            else if (strip_left != 0)
               reject_verdict = apsan_pkg::VERDICT_TOO_SHALLOW;
         end
         item = '0;
         item.is_verdict = 1'b1;
         item.verdict = reject_verdict;
         item.out_length = emitted_total;
         item.end_of_run = 1'b1;
         clean_out_due.push_back(item);
      end
   endfunction

   function automatic void queue_byte(input logic [7:0] value, input logic first_flag,
                                      input logic last_flag);
      paths_to_send.push_back('{value, first_flag, last_flag});
      queued_count++;
   endfunction

   function automatic void queue_text(input string text);
      for (int i = 0; i < text.len(); i++)
         queue_byte(text[i], i == 0, i == text.len() - 1);
   endfunction

   function automatic logic [7:0] name_char();
      logic [7:0] value;
      value = 8'($urandom_range(0, 255));
      if (value == apsan_pkg::CH_DOT || value == apsan_pkg::CH_SLASH) value = value ^ 8'h40;
      return value;
   endfunction

   // Mostly well-formed paths; a broken one loses its first or last marker.
   function automatic void queue_random_path(input bit broken);
      logic [7:0] bytes[$];
      int         parts;
      int         kind;
      bit         drop_first;
      bit         drop_last;
      parts = $urandom_range(1, 5);
      drop_first = broken && $urandom_range(0, 1);
      drop_last = broken && !drop_first;
      if ($urandom_range(0, 29) == 0) bytes.push_back(apsan_pkg::CH_SLASH);
      for (int c = 0; c < parts; c++) begin
         if (c > 0) begin
            bytes.push_back(apsan_pkg::CH_SLASH);
            if ($urandom_range(0, 9) == 0) bytes.push_back(apsan_pkg::CH_SLASH);
         end
         kind = $urandom_range(0, 99);
         if (kind < 60) begin
            bytes.push_back(name_char());
            repeat ($urandom_range(0, 5))
               bytes.push_back(($urandom_range(0, 4) == 0) ? apsan_pkg::CH_DOT : name_char());
         end else if (kind < 72) begin
            bytes.push_back(apsan_pkg::CH_DOT);
         end else if (kind < 80) begin
            bytes.push_back(apsan_pkg::CH_DOT);
            bytes.push_back(apsan_pkg::CH_DOT);
         end else if (kind < 90) begin
            repeat ($urandom_range(3, 4)) bytes.push_back(apsan_pkg::CH_DOT);
         end else begin
            repeat ($urandom_range(1, 2)) bytes.push_back(apsan_pkg::CH_DOT);
            repeat ($urandom_range(1, 3)) bytes.push_back(name_char());
         end
      end
      if ($urandom_range(0, 9) == 0) bytes.push_back(apsan_pkg::CH_SLASH);
      foreach (bytes[i])
         queue_byte(bytes[i], i == 0 && !drop_first, i == bytes.size() - 1 && !drop_last);
   endfunction

   function automatic void queue_noise();
      logic [7:0] value;
      repeat ($urandom_range(1, 6)) begin
         case ($urandom_range(0, 2))
            0: value = apsan_pkg::CH_DOT;
            1: value = apsan_pkg::CH_SLASH;
            default: value = 8'($urandom_range(0, 255));
         endcase
         queue_byte(value, $urandom_range(0, 6) == 0, $urandom_range(0, 6) == 0);
      end
   endfunction

   task automatic wait_until_drained();
      do @(negedge clock);
      while (paths_to_send.size() != 0 || req_valid || clean_out_due.size() != 0);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_csr(input logic [0:0] index, input logic [8:0] value);
      @(posedge clock);
      csr_write_enable <= 1'b1;
      csr_index <= index;
      csr_write_data <= value;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      if (index == apsan_pkg::CSR_STRIP_DEPTH) strip_setting = value[7:0];
      else length_setting = value;
   endtask

   task automatic start_phase(input logic [7:0] strip, input logic [8:0] length_cap);
      wait_until_drained();
      write_csr(apsan_pkg::CSR_STRIP_DEPTH, {1'b0, strip});
      write_csr(apsan_pkg::CSR_MAX_LENGTH, length_cap);
      sender_idles = $urandom_range(0, 3) != 0;
      receiver_stalls = $urandom_range(0, 3) != 0;
   endtask

   always @(posedge clock) begin : drive_paths
      path_item_type item;
      if (reset) begin
         req_valid <= 1'b0;
         send_gap <= 0;
      end else begin
         if (req_valid && !req_stall)
            sanitize_path_byte(req_path_byte, req_first_byte, req_last_byte);
         if (!req_valid || !req_stall) begin
            if (send_gap != 0) begin
               req_valid <= 1'b0;
               send_gap <= send_gap - 1;
            end else if (paths_to_send.size() != 0) begin
               item = paths_to_send.pop_front();
               req_valid <= 1'b1;
               req_path_byte <= item.path_byte;
               req_first_byte <= item.first_flag;
               req_last_byte <= item.last_flag;
               send_gap <= pick_gap(sender_idles);
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   always @(posedge clock) begin : check_results
      clean_out_type seen;
      clean_out_type want;
      if (!reset) begin
         if (rsp_valid && !rsp_stall) begin
            seen = {rsp_out_byte, rsp_is_verdict, rsp_verdict, rsp_out_length, rsp_end_of_run};
            want = '0;
            if (clean_out_due.size() == 0) begin
               if (fail_count < REPORT_LIMIT)
                  $display({"unexpected result: byte %02h verdict flag %0b verdict %0d",
                            " length %0d end %0b"},
                           seen.out_byte, seen.is_verdict, seen.verdict, seen.out_length,
                           seen.end_of_run);
               fail_count++;
            end else begin
               want = clean_out_due.pop_front();
               if (seen.out_byte !== want.out_byte || seen.is_verdict !== want.is_verdict ||
                   seen.verdict !== want.verdict || seen.out_length !== want.out_length ||
                   seen.end_of_run !== want.end_of_run) begin
                  if (fail_count < REPORT_LIMIT)
                     $display("mismatch: expected %02h/%0b/%0d/%0d/%0b got %02h/%0b/%0d/%0d/%0b",
                              want.out_byte, want.is_verdict, want.verdict, want.out_length,
                              want.end_of_run, seen.out_byte, seen.is_verdict, seen.verdict,
                              seen.out_length, seen.end_of_run);
                  fail_count++;
               end
            end
         end
         if (stall_left != 0) begin
            rsp_stall <= 1'b1;
            stall_left <= stall_left - 1;
         end else begin
            rsp_stall <= 1'b0;
            stall_left <= pick_gap(receiver_stalls);
         end
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("CHECKS FAILED");
         $finish;
      end
   end

   initial begin
      int target;
      int roll;
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      // Reset settings: buffered dots, absolute start, collapse and "./" removal
      // followed by a ".." component, three dots, a dot ending, one-byte paths
      // and a byte that continues a path without a first marker.
      queue_text("..b");
      queue_text("/");
      queue_text("a//./../q");
      queue_text("...");
      queue_text("x/.");
      queue_byte(8'h00, 1'b1, 1'b1);
      queue_byte(8'hFF, 1'b0, 1'b1);

      // Dots inside a stripped component, then overflow at a tight limit.
      start_phase(8'd1, 9'd1);
      queue_text(".x/cd");

      start_phase(8'd255, 9'd0);
      queue_text("a");

      for (int p = 0; p < 7; p++) begin
         case (p)
            0: start_phase(8'd0, apsan_pkg::LENGTH_MAX);
            1: start_phase(8'd1, apsan_pkg::LENGTH_MAX);
            2: start_phase(8'd2, 9'($urandom_range(0, 40)));
            3: start_phase(8'd255, apsan_pkg::LENGTH_MAX);
            4: start_phase(8'd0, 9'd0);
            default: start_phase(8'($urandom_range(0, 3)),
                                 ($urandom_range(0, 1) != 0) ? 9'($urandom_range(0, 20))
                                                             : 9'($urandom_range(0, 511)));
         endcase
         target = queued_count + PHASE_ITEMS;
         while (queued_count < target) begin
            roll = $urandom_range(0, 9);
            if (roll < 8) queue_random_path(1'b0);
            else if (roll == 8) queue_random_path(1'b1);
            else queue_noise();
         end
      end

      wait_until_drained();
      if (fail_count == 0 && clean_out_due.size() == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end
endmodule
